// File: src/sha1s_pkg.sv
// Shared types and constants of the streaming SHA-1 hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
package sha1s_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int DIGEST_W    = 5 * WORD_W;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    localparam logic [WORD_W-1:0] IV [0:4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [WORD_W-1:0] K0 = 32'h5a827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ed9eba1;
    localparam logic [WORD_W-1:0] K2 = 32'h8f1bbcdc;
    localparam logic [WORD_W-1:0] K3 = 32'hca62c1d6;

    typedef enum logic [1:0] {
        SEL_INPUT = 2'd0,
        SEL_PAD   = 2'd1,
        SEL_ZERO  = 2'd2
    } byte_sel_t;

    typedef struct packed {
        logic      place_byte;
        byte_sel_t byte_sel;
        logic      push_len_hi;
        logic      push_len_lo;
        logic      start_comp;
        logic      round_en;
        logic      chain_add;
        logic      finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic       round_last;
        logic       out_free;
    } dp_status_t;

endpackage

// File: src/sha1_stream_hasher_top.sv
// Channel   Dir  Ports                                    Beat content
// s_        in   s_tvalid s_tready s_tdata s_tuser s_tlast one message byte, flag, end mark
// m_        out  m_tvalid m_tready m_tdata                 five digest words
//
// The 64th byte of a block adds 80 rounds and one chain update.
// A final beat adds the pad bytes (1 to 64), a step at the length slot, the two length
// words, one or two compressions and a load of the digest register.
// Reset is synchronous, active low, and clears the chain to the initial value.
// A digest waits in its register under back-pressure while the next message streams
// in; only that message's own digest load waits for m_tready.
module sha1_stream_hasher_top
    import sha1s_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tuser,   // [0] byte_present
    input  logic                s_tlast,   // last_item
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DIGEST_W-1:0] m_tdata    // digest_h0, h1, h2, h3, h4, 32 bits each
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sha1s_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .byte_present (s_tuser),
        .last_item    (s_tlast),
        .s_tready     (s_tready),
        .status       (status),
        .cmd          (cmd)
    );

    sha1s_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .data_byte (s_tdata),
        .m_tready  (m_tready),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .digest    (m_tdata)
    );

endmodule

// File: src/sha1s_dp.sv
// Datapath of the SHA-1 hasher: byte packing, block shift line used as the
// message schedule, round logic, chain value, length count and output register.
// Depends on sha1s_pkg.
module sha1s_dp
    import sha1s_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    input  logic [7:0]          data_byte,
    input  logic                m_tready,
    output dp_status_t          status,
    output logic                m_tvalid,
    output logic [DIGEST_W-1:0] digest
);

    logic [WORD_W-1:0] chain_reg [0:4];
    logic [WORD_W-1:0] sched_reg [0:BLOCK_WORDS-1];
    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [23:0]       acc_reg;
    logic [5:0]        pos_reg;
    logic [60:0]       total_reg;
    logic [6:0]        round_reg;
    logic [DIGEST_W-1:0] digest_reg;
    logic              m_valid_reg;

    logic [7:0]        byte_val;
    logic [63:0]       bit_len;
    logic [WORD_W-1:0] w_mix, w_new, f_val, k_val, t_val, shift_word;
    logic              shift_en;

    always_comb begin
        unique case (cmd.byte_sel)
            SEL_INPUT: byte_val = data_byte;
            SEL_PAD:   byte_val = PAD_BYTE;
            SEL_ZERO:  byte_val = 8'h00;
            default:   byte_val = 8'h00;
        endcase
    end

    assign bit_len = {total_reg, 3'b000};

    // During the rounds the shift line holds W[r..r+15] and the word pushed in is W[r+16].
    assign w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

    always_comb begin
        priority if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) ^ (~b_reg & d_reg);
            k_val = K0;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) ^ (b_reg & d_reg) ^ (c_reg & d_reg);
            k_val = K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + sched_reg[0];

    assign shift_en = (cmd.place_byte && (pos_reg[1:0] == 2'd3)) ||
                      cmd.push_len_hi || cmd.push_len_lo || cmd.round_en;

    always_comb begin
        priority if (cmd.round_en) begin
            shift_word = w_new;
        end else if (cmd.push_len_hi) begin
            shift_word = bit_len[63:32];
        end else if (cmd.push_len_lo) begin
            shift_word = bit_len[31:0];
        end else begin
            shift_word = {acc_reg, byte_val};
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.place_byte) begin
            acc_reg <= {acc_reg[15:0], byte_val};
        end
        if (shift_en) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BLOCK_WORDS-1] <= shift_word;
        end
        if (cmd.start_comp) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (cmd.round_en) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.finish) begin
            digest_reg <= {chain_reg[4], chain_reg[3], chain_reg[2], chain_reg[1],
                           chain_reg[0]};
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) begin
                chain_reg[i] <= IV[i];
            end
            pos_reg     <= '0;
            total_reg   <= '0;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                for (int i = 0; i < 5; i++) begin
                    chain_reg[i] <= IV[i];
                end
            end else if (cmd.chain_add) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end

            if (cmd.finish) begin
                pos_reg <= '0;
            end else if (cmd.place_byte) begin
                pos_reg <= pos_reg + 6'd1;
            end else if (cmd.push_len_hi || cmd.push_len_lo) begin
                pos_reg <= pos_reg + 6'd4;
            end

            if (cmd.finish) begin
                total_reg <= '0;
            end else if (cmd.place_byte && (cmd.byte_sel == SEL_INPUT)) begin
                total_reg <= total_reg + 61'd1;
            end

            if (cmd.start_comp) begin
                round_reg <= '0;
            end else if (cmd.round_en) begin
                round_reg <= round_reg + 7'd1;
            end

            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.pos        = pos_reg;
    assign status.round_last = (round_reg == LAST_ROUND);
    assign status.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign digest   = digest_reg;

endmodule

// File: src/sha1s_ctrl.sv
// Controller of the SHA-1 hasher: sequences byte intake, padding, length words,
// the 80 compression rounds, the chain update and the digest hand-off.
// Depends on sha1s_pkg.
module sha1s_ctrl
    import sha1s_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       byte_present,
    input  logic       last_item,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PAD    = 7'b0000010,
        ST_LEN_HI = 7'b0000100,
        ST_LEN_LO = 7'b0001000,
        ST_COMP   = 7'b0010000,
        ST_ADD    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;
    logic   sent80_reg, sent80_next;
    logic   lenp_reg, lenp_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        fin_next    = fin_reg;
        sent80_next = sent80_reg;
        lenp_next   = lenp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.place_byte = byte_present;
                    cmd.byte_sel   = SEL_INPUT;
                    fin_next       = last_item;
                    sent80_next    = 1'b0;
                    lenp_next      = 1'b0;
                    if (byte_present && (status.pos == LAST_POS)) begin
                        cmd.start_comp = 1'b1;
                        state_next     = ST_COMP;
                    end else if (last_item) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (!sent80_reg) begin
                    cmd.place_byte = 1'b1;
                    cmd.byte_sel   = SEL_PAD;
                    sent80_next    = 1'b1;
                    if (status.pos == LAST_POS) begin
                        cmd.start_comp = 1'b1;
                        state_next     = ST_COMP;
                    end
                end else if (status.pos == LEN_POS) begin
                    state_next = ST_LEN_HI;
                end else begin
                    cmd.place_byte = 1'b1;
                    cmd.byte_sel   = SEL_ZERO;
                    if (status.pos == LAST_POS) begin
                        cmd.start_comp = 1'b1;
                        state_next     = ST_COMP;
                    end
                end
            end
            ST_LEN_HI: begin
                cmd.push_len_hi = 1'b1;
                state_next      = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                cmd.push_len_lo = 1'b1;
                cmd.start_comp  = 1'b1;
                lenp_next       = 1'b1;
                state_next      = ST_COMP;
            end
            ST_COMP: begin
                cmd.round_en = 1'b1;
                if (status.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
                priority if (lenp_reg) begin
                    state_next = ST_DONE;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                // Hold the digest in the chain until the output register is free.
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    fin_next   = 1'b0;
                    lenp_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fin_reg    <= 1'b0;
            sent80_reg <= 1'b0;
            lenp_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            sent80_reg <= sent80_next;
            lenp_reg   <= lenp_next;
        end
    end

endmodule

// File: src/sha1s_checker.sv
// Port-level checks of the SHA-1 hasher, bound to the top level.
// Depends on sha1s_pkg.
module sha1s_checker
    import sha1s_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [DIGEST_W-1:0] m_tdata
);

    // A stalled digest stays offered.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("digest beat dropped under back-pressure");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("digest changed under back-pressure");

    // An end-of-message beat always starts padding or a compression.
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after an end-of-message beat");

    // A new digest only comes out of the finishing sequence, never from intake.
    a_digest_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("digest appeared while the block was taking bytes");

endmodule

bind sha1_stream_hasher_top sha1s_checker u_sha1s_checker (.*);

// File: verif/tb_top.sv
// Self-checking testbench for sha1_stream_hasher_top: streams random and boundary-length
// messages byte by byte and checks each digest against a SHA-1 predictor kept in the bench.
// Depends on sha1s_pkg and the top level of the hasher.
module tb_top;
    import sha1s_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int TAIL_CYCLES  = 400;
    localparam int HOLD_CYCLES  = 3000;
    localparam int IDLE_PCT     = 28;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } msg_beat_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [DIGEST_W-1:0] m_tdata;

    msg_beat_t           beat_q [$];
    logic [DIGEST_W-1:0] digest_q [$];
    msg_beat_t           cur_beat;

    // Running SHA-1 state of the message being predicted.
    logic [31:0] hash_chain [0:4];
    logic [31:0] pred_words [0:15];
    logic [60:0] msg_len;

    int beats_taken;
    int digests_seen;
    int mismatches;
    int hold_left;
    bit hold_done;
    int cycle_cnt;
    bit calm;

    sha1_stream_hasher_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [0:15];
        logic [31:0] a, b, c, d, e, f, k, t, wt;
        for (int i = 0; i < 16; i++) w[i] = pred_words[i];
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
                wt = w[4'(r)];
            end else begin
                wt = rotl32(w[4'(r - 3)] ^ w[4'(r - 8)] ^ w[4'(r - 14)] ^ w[4'(r)], 1);
                w[4'(r)] = wt;
            end
            if (r < 20) begin
                f = (b & c) ^ (~b & d);
                k = K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (r < 60) begin
                f = (b & c) ^ (b & d) ^ (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rotl32(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        hash_chain[0] = hash_chain[0] + a;
        hash_chain[1] = hash_chain[1] + b;
        hash_chain[2] = hash_chain[2] + c;
        hash_chain[3] = hash_chain[3] + d;
        hash_chain[4] = hash_chain[4] + e;
    endfunction

    // Bytes go in big-endian; the 64th byte of a block runs the compression.
    function automatic void absorb_byte(input logic [5:0] pos, input logic [7:0] val);
        logic [31:0] shifted;
        shifted = {24'd0, val} << ((3 - pos[1:0]) * 8);
        if (pos[1:0] == 2'd0)
            pred_words[pos[5:2]] = shifted;
        else
            pred_words[pos[5:2]] = pred_words[pos[5:2]] | shifted;
        if (pos == 6'd63)
            sha1_compress();
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 5; i++) hash_chain[i] = IV[i];
        msg_len = '0;
    endfunction

    function automatic void predict_beat(input msg_beat_t bt);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        if (bt.present) begin
            absorb_byte(msg_len[5:0], bt.data);
            msg_len = msg_len + 61'd1;
        end
        if (!bt.last)
            return;
        pos = msg_len[5:0];
        absorb_byte(pos, PAD_BYTE);
        pos = pos + 6'd1;
        while (pos != LEN_POS) begin
            absorb_byte(pos, 8'h00);
            pos = pos + 6'd1;
        end
        bit_len = {msg_len, 3'b000};
        pred_words[14] = bit_len[63:32];
        pred_words[15] = bit_len[31:0];
        sha1_compress();
        digest_q.push_back({hash_chain[4], hash_chain[3], hash_chain[2],
                            hash_chain[1], hash_chain[0]});
        restart_hash();
    endfunction

    // A stretch of the run where neither side idles.
    assign calm = (beats_taken >= 400) && (beats_taken < 700);

    // Driver: predicts each accepted beat, then offers the next one or idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_beat(cur_beat);
                beats_taken <= beats_taken + 1;
            end
            if (beat_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                cur_beat = beat_q.pop_front();
                s_tdata  <= cur_beat.data;
                s_tuser  <= cur_beat.present;
                s_tlast  <= cur_beat.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // One long hold-off of the digest channel, so that the next message backs up.
    always @(posedge aclk) begin
        if (!hold_done && digests_seen == 4) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each digest beat against the oldest prediction.
    always @(posedge aclk) begin : digest_check
        logic [DIGEST_W-1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                digests_seen <= digests_seen + 1;
                if (digest_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("digest beat with nothing expected: %h", m_tdata);
                end else begin
                    want = digest_q.pop_front();
                    for (int i = 0; i < 5; i++) begin
                        if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                            mismatches = mismatches + 1;
                            if (mismatches <= MAX_REPORTS)
                                $display("digest %0d word h%0d: expected %h, got %h",
                                         digests_seen, i, want[32*i +: 32],
                                         m_tdata[32*i +: 32]);
                        end
                    end
                end
            end
            m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("[sha1_stream_hasher_top] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int  len;
        int  beat_cnt;
        bit  tail_on_byte;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        beats_taken  = 0;
        digests_seen = 0;
        mismatches   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        cycle_cnt    = 0;
        beat_cnt     = 0;
        restart_hash();
        for (int i = 0; i < 16; i++) pred_words[i] = '0;

        // Directed: empty message, ignored beats, one-byte messages with the end mark
        // on the byte, "abc" closed by an empty end beat, and extremes of the byte.
        beat_q.push_back({8'hA5, 1'b0, 1'b1});
        beat_q.push_back({8'hFF, 1'b0, 1'b0});
        beat_q.push_back({8'h00, 1'b1, 1'b1});
        beat_q.push_back({8'hFF, 1'b1, 1'b1});
        beat_q.push_back({8'h61, 1'b1, 1'b0});
        beat_q.push_back({8'h62, 1'b1, 1'b0});
        beat_q.push_back({8'h63, 1'b1, 1'b0});
        beat_q.push_back({8'h00, 1'b0, 1'b1});
        beat_q.push_back({8'h80, 1'b1, 1'b0});
        beat_q.push_back({8'h55, 1'b0, 1'b0});
        beat_q.push_back({8'h00, 1'b0, 1'b0});
        beat_q.push_back({8'h7F, 1'b1, 1'b1});
        beat_q.push_back({8'h00, 1'b0, 1'b1});

        // Random messages; a quarter have lengths around the padding boundaries.
        while (beat_cnt < 1000) begin
            if ($urandom_range(3) == 0)
                len = 64 * $urandom_range(1) + 54 + $urandom_range(11);
            else
                len = $urandom_range(40);
            tail_on_byte = (len > 0) && ($urandom_range(1) == 1);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(19) == 0)
                    beat_q.push_back({8'($urandom_range(255)), 1'b0, 1'b0});
                beat_q.push_back({8'($urandom_range(255)), 1'b1,
                                  1'(tail_on_byte && j == len - 1)});
            end
            if (!tail_on_byte)
                beat_q.push_back({8'($urandom_range(255)), 1'b0, 1'b1});
            beat_cnt = beat_cnt + len + (tail_on_byte ? 0 : 1);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (beat_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("[sha1_stream_hasher_top] OK");
        else
            $display("[sha1_stream_hasher_top] ERROR");
        $finish;
    end

endmodule
